>>> rtl/core/eif_pkg.sv
// Shared constants, register indexes and table construction for the exponential
// integrate-and-fire neuron step block. Used by eif_exp_rom and the top level.
// Depends on nothing else.
package eif_pkg;

  localparam int unsigned EXP_TABLE_ADDR_BITS_DEF = 8;
  localparam int unsigned POW2_W = 17;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_REST_LEVEL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAK_RATE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXP_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCITE_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_SLOPE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_LEVEL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LEVEL = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY_TICKS = 3'd7;

  localparam logic signed [15:0] RST_REST_LEVEL = -16'sd18074;
  localparam logic [15:0] RST_LEAK_RATE = 16'd700;
  localparam logic [15:0] RST_EXP_GAIN = 16'd1399;
  localparam logic signed [15:0] RST_EXCITE_THRESHOLD = -16'sd12902;
  localparam logic [15:0] RST_INV_SLOPE = 16'd128;
  localparam logic signed [15:0] RST_SPIKE_LEVEL = 16'sd10240;
  localparam logic signed [15:0] RST_RESET_LEVEL = -16'sd18074;
  localparam logic [7:0] RST_REFRACTORY_TICKS = 8'd20;
  localparam logic signed [15:0] RST_VOLTAGE = -16'sd18074;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [20:0] EXP_CAP = 21'h100000;

  function automatic longint unsigned isqrt64(longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One entry of the table of 2^(idx / 2^abits) in Q16, built from repeated
  // square roots of two in Q30 with products rounded to nearest.
  function automatic logic [POW2_W-1:0] pow2_entry(int unsigned idx, int unsigned abits);
    longint unsigned root [13];
    longint unsigned acc;
    int unsigned j;
    root[0] = 64'd1 << 31;
    for (j = 1; j <= abits; j++) begin
      root[j] = isqrt64(root[j-1] << 30);
    end
    acc = 64'd1 << 30;
    for (j = 0; j < abits; j++) begin
      if (((idx >> j) & 1) != 0) begin
        acc = (acc * root[abits-j] + (64'd1 << 29)) >> 30;
      end
    end
    return POW2_W'((acc + (64'd1 << 13)) >> 14);
  endfunction

endpackage

>>> rtl/core/eif_exp_rom.sv
// Constant table of fractional powers of two, 2^(i/2^ADDR_BITS) in Q16,
// with a registered read port. Depends on eif_pkg.
module eif_exp_rom #(
  parameter int unsigned ADDR_BITS = eif_pkg::EXP_TABLE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic [ADDR_BITS-1:0]        addr,
  output logic [eif_pkg::POW2_W-1:0]  data_r
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [eif_pkg::POW2_W-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [eif_pkg::POW2_W-1:0] ENTRY = eif_pkg::pow2_entry(i, ADDR_BITS);
    assign rom[i] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

endmodule

>>> rtl/core/exp_integrate_fire_neuron_step.sv
// Exponential integrate-and-fire neuron, one forward-Euler tick per transfer.
// A spiking or refractory tick goes from input transfer straight to S_PUT; an
// integrating tick passes S_LEAK, S_ARG, S_EXPY, S_TAB, S_PROD, S_SHIFT, S_SUM,
// with one table read and four products in turn on one shared 22 x 17 bit multiplier.
// One item is in flight at a time. Synchronous active-low reset restores the
// registers and the membrane state to their defaults; no clearing pass.
module exp_integrate_fire_neuron_step #(
  parameter int unsigned EXP_TABLE_ADDR_BITS = eif_pkg::EXP_TABLE_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_stimulus_step,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_membrane_voltage,
  output logic                                out_spike,
  input  logic                                cfg_we,
  input  logic [eif_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [eif_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LEAK  = 4'd1;
  localparam logic [3:0] S_ARG   = 4'd2;
  localparam logic [3:0] S_EXPY  = 4'd3;
  localparam logic [3:0] S_TAB   = 4'd4;
  localparam logic [3:0] S_PROD  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_PUT   = 4'd8;

  localparam logic signed [39:0] ARG_MAX = 40'sd2097151;
  localparam logic signed [39:0] ARG_MIN = -40'sd2097152;

  logic signed [15:0] rest_level_r;
  logic [15:0]        leak_rate_r;
  logic [15:0]        exp_gain_r;
  logic signed [15:0] excite_threshold_r;
  logic [15:0]        inv_slope_r;
  logic signed [15:0] spike_level_r;
  logic signed [15:0] reset_level_r;
  logic [7:0]         refractory_ticks_r;

  logic [3:0]         state_r, state_nxt;
  logic signed [15:0] u_r, u_nxt;
  logic [7:0]         refr_r, refr_nxt;
  logic               spike_r, spike_nxt;
  logic signed [15:0] stim_r, stim_nxt;
  logic signed [39:0] prod_r, prod_nxt;
  logic signed [16:0] leak_r, leak_nxt;
  logic signed [7:0]  n_r, n_nxt;
  logic [20:0]        exp_r, exp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_volt_r, out_volt_nxt;
  logic               out_spike_r, out_spike_nxt;

  logic signed [21:0] mul_a;
  logic [16:0]        mul_b;
  logic signed [17:0] mul_b_s;
  logic signed [39:0] mul_p;

  logic [EXP_TABLE_ADDR_BITS-1:0] rom_addr;
  logic [eif_pkg::POW2_W-1:0]     rom_data;

  logic               in_xfer;
  logic               out_free;
  logic [7:0]         refr_dec;
  logic signed [21:0] x_sat;
  logic [32:0]        p_mag;
  logic signed [8:0]  sh_s;
  logic [8:0]         sh_neg;
  logic [53:0]        shl_val;
  logic [32:0]        shr_val;
  logic [20:0]        exp_val;
  logic signed [22:0] sum_v;
  logic signed [22:0] spike_ext;
  logic signed [22:0] clamp_v;

  eif_exp_rom #(
    .ADDR_BITS(EXP_TABLE_ADDR_BITS)
  ) u_exp_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_membrane_voltage = out_volt_r;
  assign out_spike = out_spike_r;

  assign mul_b_s = signed'({1'b0, mul_b});
  assign mul_p = 40'(mul_a) * 40'(mul_b_s);
  assign rom_addr = prod_r[31:32-EXP_TABLE_ADDR_BITS];
  assign refr_dec = (refr_r != 8'd0) ? refr_r - 8'd1 : 8'd0;

  always_comb begin
    if (prod_r > ARG_MAX) begin
      x_sat = 22'(ARG_MAX);
    end else if (prod_r < ARG_MIN) begin
      x_sat = 22'(ARG_MIN);
    end else begin
      x_sat = prod_r[21:0];
    end
  end

  always_comb begin
    p_mag = prod_r[32:0];
    sh_s = 9'(n_r) - 9'sd24;
    sh_neg = 9'(-sh_s);
    shl_val = {21'd0, p_mag} << sh_s[4:0];
    shr_val = p_mag >> sh_neg[5:0];
    if (!sh_s[8]) begin
      if (p_mag == 33'd0) begin
        exp_val = 21'd0;
      end else if (sh_s > 9'sd20) begin
        exp_val = eif_pkg::EXP_CAP;
      end else if (shl_val > 54'(eif_pkg::EXP_CAP)) begin
        exp_val = eif_pkg::EXP_CAP;
      end else begin
        exp_val = shl_val[20:0];
      end
    end else if (sh_neg >= 9'd33) begin
      exp_val = 21'd0;
    end else if (shr_val > 33'(eif_pkg::EXP_CAP)) begin
      exp_val = eif_pkg::EXP_CAP;
    end else begin
      exp_val = shr_val[20:0];
    end
  end

  always_comb begin
    sum_v = 23'(u_r) + 23'(leak_r) + signed'({2'b00, exp_r}) + 23'(stim_r);
    spike_ext = 23'(spike_level_r);
    if (sum_v > spike_ext) begin
      clamp_v = spike_ext;
    end else if (sum_v < -23'sd32768) begin
      clamp_v = -23'sd32768;
    end else begin
      clamp_v = sum_v;
    end
  end

  always_comb begin
    state_nxt = state_r;
    u_nxt = u_r;
    refr_nxt = refr_r;
    spike_nxt = spike_r;
    stim_nxt = stim_r;
    prod_nxt = prod_r;
    leak_nxt = leak_r;
    n_nxt = n_r;
    exp_nxt = exp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_volt_nxt = out_volt_r;
    out_spike_nxt = out_spike_r;
    mul_a = 22'(17'(rest_level_r) - 17'(u_r));
    mul_b = {1'b0, leak_rate_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          stim_nxt = in_stimulus_step;
          if (u_r == spike_level_r) begin
            u_nxt = reset_level_r;
            refr_nxt = refractory_ticks_r;
            spike_nxt = 1'b1;
            state_nxt = S_PUT;
          end else begin
            refr_nxt = refr_dec;
            spike_nxt = 1'b0;
            if (refr_dec != 8'd0) begin
              u_nxt = reset_level_r;
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_LEAK;
            end
          end
        end
      end
      S_LEAK: begin
        prod_nxt = mul_p;
        state_nxt = S_ARG;
      end
      S_ARG: begin
        leak_nxt = prod_r[32:16];
        mul_a = 22'(17'(u_r) - 17'(excite_threshold_r));
        mul_b = {1'b0, inv_slope_r};
        prod_nxt = mul_p;
        state_nxt = S_EXPY;
      end
      S_EXPY: begin
        mul_a = x_sat;
        mul_b = eif_pkg::LOG2E_Q16;
        prod_nxt = mul_p;
        state_nxt = S_TAB;
      end
      S_TAB: begin
        n_nxt = prod_r[39:32];
        state_nxt = S_PROD;
      end
      S_PROD: begin
        mul_a = signed'({6'd0, exp_gain_r});
        mul_b = rom_data;
        prod_nxt = mul_p;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        exp_nxt = exp_val;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        u_nxt = clamp_v[15:0];
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_volt_nxt = u_r;
          out_spike_nxt = spike_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      u_r <= eif_pkg::RST_VOLTAGE;
      refr_r <= 8'd0;
      spike_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      u_r <= u_nxt;
      refr_r <= refr_nxt;
      spike_r <= spike_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stim_r <= stim_nxt;
    prod_r <= prod_nxt;
    leak_r <= leak_nxt;
    n_r <= n_nxt;
    exp_r <= exp_nxt;
    out_volt_r <= out_volt_nxt;
    out_spike_r <= out_spike_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_level_r <= eif_pkg::RST_REST_LEVEL;
      leak_rate_r <= eif_pkg::RST_LEAK_RATE;
      exp_gain_r <= eif_pkg::RST_EXP_GAIN;
      excite_threshold_r <= eif_pkg::RST_EXCITE_THRESHOLD;
      inv_slope_r <= eif_pkg::RST_INV_SLOPE;
      spike_level_r <= eif_pkg::RST_SPIKE_LEVEL;
      reset_level_r <= eif_pkg::RST_RESET_LEVEL;
      refractory_ticks_r <= eif_pkg::RST_REFRACTORY_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eif_pkg::REG_REST_LEVEL:       rest_level_r <= cfg_wdata;
        eif_pkg::REG_LEAK_RATE:        leak_rate_r <= cfg_wdata;
        eif_pkg::REG_EXP_GAIN:         exp_gain_r <= cfg_wdata;
        eif_pkg::REG_EXCITE_THRESHOLD: excite_threshold_r <= cfg_wdata;
        eif_pkg::REG_INV_SLOPE:        inv_slope_r <= cfg_wdata;
        eif_pkg::REG_SPIKE_LEVEL:      spike_level_r <= cfg_wdata;
        eif_pkg::REG_RESET_LEVEL:      reset_level_r <= cfg_wdata;
        eif_pkg::REG_REFRACTORY_TICKS: refractory_ticks_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for exp_integrate_fire_neuron_step: drives neuron ticks under
// several register settings and checks every result against its own tick predictor.
// Depends on eif_pkg for the register indexes and port widths.
module testbench;

  typedef struct packed {
    logic signed [15:0] voltage;
    logic               spike;
  } tick_result_t;

  localparam int     DRAIN_CYCLES = 12;
  localparam longint LOG2E_FIX = 94548;
  localparam longint BOOST_CAP = 64'sd1 <<< 20;
  localparam longint ARG_SPAN = 64'sd32 <<< 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_stimulus_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_membrane_voltage;
  logic out_spike;
  logic cfg_we = 1'b0;
  logic [eif_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [eif_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register shadows and membrane state of the predictor.
  int cfg_rest, cfg_leak, cfg_gain, cfg_thr, cfg_slope, cfg_spike, cfg_reset, cfg_refr;
  int v_model, refr_left;
  longint unsigned pow2_q16 [256];

  logic [15:0] pending_stim [$];
  tick_result_t expected_ticks [$];
  int err_count = 0;
  int ticks_done = 0;
  int spikes_seen = 0;
  int settings_used = 1;
  bit steady = 1'b0;

  exp_integrate_fire_neuron_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_stimulus_step(in_stimulus_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_membrane_voltage(out_membrane_voltage), .out_spike(out_spike),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    int b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic void build_pow2_table();
    longint unsigned roots [9];
    longint unsigned acc;
    int i;
    int j;
    roots[0] = 64'd1 << 31;
    for (j = 1; j <= 8; j++) roots[j] = floor_sqrt(roots[j-1] << 30);
    for (i = 0; i < 256; i++) begin
      acc = 64'd1 << 30;
      for (j = 0; j < 8; j++) begin
        if (((i >> j) & 1) != 0) acc = (acc * roots[8-j] + (64'd1 << 29)) >> 30;
      end
      pow2_q16[i] = (acc + (64'd1 << 13)) >> 14;
    end
  endfunction

  function automatic longint exp_boost(int u);
    longint arg;
    longint biased;
    longint prod;
    int whole;
    int sh;
    arg = (longint'(u) - longint'(cfg_thr)) * longint'(cfg_slope);
    if (arg > ARG_SPAN - 1) arg = ARG_SPAN - 1;
    if (arg < -ARG_SPAN) arg = -ARG_SPAN;
    biased = arg * LOG2E_FIX + (64'sd1 <<< 40);
    whole = int'(biased >>> 32) - 256;
    prod = longint'(cfg_gain) * longint'(pow2_q16[(biased >>> 24) & 255]);
    sh = whole - 24;
    if (sh >= 0) begin
      if (prod == 0) return 0;
      if (sh > 20) return BOOST_CAP;
      prod = prod <<< sh;
    end else begin
      if (-sh >= 64) return 0;
      prod = prod >>> (-sh);
    end
    return (prod > BOOST_CAP) ? BOOST_CAP : prod;
  endfunction

  function automatic tick_result_t neuron_tick(logic signed [15:0] stim);
    tick_result_t res;
    longint leak;
    longint total;
    res.spike = 1'b0;
    if (v_model == cfg_spike) begin
      v_model = cfg_reset;
      refr_left = cfg_refr;
      res.spike = 1'b1;
    end else begin
      if (refr_left > 0) refr_left--;
      if (refr_left > 0) begin
        v_model = cfg_reset;
      end else begin
        leak = ((longint'(cfg_rest) - longint'(v_model)) * longint'(cfg_leak)) >>> 16;
        total = longint'(v_model) + leak + exp_boost(v_model) + longint'(stim);
        if (total > cfg_spike) total = cfg_spike;
        if (total > 32767) total = 32767;
        if (total < -32768) total = -32768;
        v_model = int'(total);
      end
    end
    res.voltage = 16'(v_model);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // Sender: the expectation is formed at the edge where the transfer happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_ticks.push_back(neuron_tick(in_stimulus_step));
      if (!in_valid || !in_stall) begin
        if (pending_stim.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
          in_valid <= 1'b1;
          in_stimulus_step <= pending_stim.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        ticks_done++;
        if (expected_ticks.size() == 0) begin
          flag_mismatch("result with no tick outstanding", out_membrane_voltage, 0);
        end else begin
          want = expected_ticks.pop_front();
          if (out_membrane_voltage !== want.voltage)
            flag_mismatch("membrane_voltage", out_membrane_voltage, want.voltage);
          if (out_spike !== want.spike) flag_mismatch("spike", out_spike, want.spike);
          if (want.spike) spikes_seen++;
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 6);
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_stim.size() != 0 || in_valid || expected_ticks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [eif_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      eif_pkg::REG_REST_LEVEL:       cfg_rest = int'($signed(data));
      eif_pkg::REG_LEAK_RATE:        cfg_leak = int'(data);
      eif_pkg::REG_EXP_GAIN:         cfg_gain = int'(data);
      eif_pkg::REG_EXCITE_THRESHOLD: cfg_thr = int'($signed(data));
      eif_pkg::REG_INV_SLOPE:        cfg_slope = int'(data);
      eif_pkg::REG_SPIKE_LEVEL:      cfg_spike = int'($signed(data));
      eif_pkg::REG_RESET_LEVEL:      cfg_reset = int'($signed(data));
      eif_pkg::REG_REFRACTORY_TICKS: cfg_refr = int'(data[7:0]);
      default: ;
    endcase
  endtask

  task automatic load_settings(input int rest, input int leak, input int gain, input int thr,
                               input int slope, input int spike, input int rlevel,
                               input int refr);
    wait_idle();
    write_reg(eif_pkg::REG_REST_LEVEL, 16'(rest));
    write_reg(eif_pkg::REG_LEAK_RATE, 16'(leak));
    write_reg(eif_pkg::REG_EXP_GAIN, 16'(gain));
    write_reg(eif_pkg::REG_EXCITE_THRESHOLD, 16'(thr));
    write_reg(eif_pkg::REG_INV_SLOPE, 16'(slope));
    write_reg(eif_pkg::REG_SPIKE_LEVEL, 16'(spike));
    write_reg(eif_pkg::REG_RESET_LEVEL, 16'(rlevel));
    write_reg(eif_pkg::REG_REFRACTORY_TICKS, 16'(refr));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] draw_stimulus(int lo, int hi);
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return 16'(int'($urandom_range(hi - lo)) + lo);
    if (pick < 90) return 16'($urandom);
    return pick[0] ? 16'h7FFF : 16'h8000;
  endfunction

  task automatic queue_random(input int count, input int lo, input int hi);
    repeat (count) pending_stim.push_back(draw_stimulus(lo, hi));
  endtask

  initial begin
    int rest;
    int k;
    build_pow2_table();
    cfg_rest = -18074; cfg_leak = 700; cfg_gain = 1399; cfg_thr = -12902;
    cfg_slope = 128; cfg_spike = 10240; cfg_reset = -18074; cfg_refr = 20;
    v_model = -18074; refr_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: extremes, a forced spike and the refractory hold after it.
    pending_stim = '{16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                     16'h5555, 16'hAAAA, 16'h0000, 16'h0400, 16'h0000, 16'hFC00};
    repeat (8) pending_stim.push_back(16'h0000);
    queue_random(140, -200, 1500);

    // Every magnitude at its top: the exponential saturates and refractoriness is zero.
    load_settings(32767, 65535, 65535, -32768, 65535, 32767, -32768, 16'hAB00);
    queue_random(40, -2000, 2000);

    // The opposite corner: no leak, no exponential, a refractory setting of one.
    load_settings(-32768, 0, 0, 32767, 0, -32768, 32767, 16'h5401);
    queue_random(30, -30000, 2000);

    // Spike level out of reach of a slowly falling membrane.
    load_settings(-18074, 700, 0, -12902, 128, 30000, -18074, 1);
    repeat (30) pending_stim.push_back(16'(int'($urandom_range(1100)) - 800));

    for (k = 0; k < 3; k++) begin
      rest = int'($urandom_range(8000)) - 22000;
      load_settings(rest, $urandom_range(4000), $urandom_range(6000),
                    rest + int'($urandom_range(9000)), $urandom_range(400),
                    int'($urandom_range(16000)) - 2000, rest - int'($urandom_range(2000)),
                    ($urandom & 16'hFF00) | ((k == 0) ? 1 : $urandom_range(30)));
      steady = (k == 1);
      queue_random(50, -200, 1500);
    end

    wait_idle();
    $display("Checked %0d neuron ticks under %0d register settings, %0d spike resets among them.",
             ticks_done, settings_used, spikes_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
